@@ design/tilt_orientation_classifier_macros.svh @@
// assertion macros shared by the tilt orientation classifier rtl
`ifndef TILT_ORIENTATION_CLASSIFIER_MACROS_SVH
`define TILT_ORIENTATION_CLASSIFIER_MACROS_SVH
`ifndef SYNTH
// overlapping implication, checked out of reset
`define TOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define TOC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TOC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/toc_pkg.sv @@
// types, codes and helpers shared by the tilt orientation classifier
package toc_pkg;

    localparam int ACC_W  = 13;
    localparam int MAG_W  = 13;
    localparam int THR_W  = 12;
    localparam int SQ_W   = 25;
    localparam int SUM_W  = 26;
    localparam int ORI_W  = 5;
    localparam int CIDX_W = 2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_UPPER = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_LOWER = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_EDGE  = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_TILT  = 2'd3;

    // register reset values
    localparam logic [MAG_W-1:0] UPPER_RST    = 13'd1200;
    localparam logic [MAG_W-1:0] LOWER_RST    = 13'd800;
    localparam logic [THR_W-1:0] EDGE_RST     = 12'd850;
    localparam logic [THR_W-1:0] TILT_RST     = 12'd500;
    localparam logic [SUM_W-1:0] UPPER_SQ_RST = 26'd1440000;
    localparam logic [SUM_W-1:0] LOWER_SQ_RST = 26'd640000;

    // orientation codes
    localparam logic [ORI_W-1:0] ORI_ACCEL           = 5'd0;
    localparam logic [ORI_W-1:0] ORI_FALL            = 5'd1;
    localparam logic [ORI_W-1:0] ORI_FACE_UP         = 5'd2;
    localparam logic [ORI_W-1:0] ORI_FACE_DOWN       = 5'd3;
    localparam logic [ORI_W-1:0] ORI_LEFT_EDGE       = 5'd4;
    localparam logic [ORI_W-1:0] ORI_RIGHT_EDGE      = 5'd5;
    localparam logic [ORI_W-1:0] ORI_BACK_EDGE       = 5'd6;
    localparam logic [ORI_W-1:0] ORI_FRONT_EDGE      = 5'd7;
    localparam logic [ORI_W-1:0] ORI_TILT_FWD        = 5'd8;
    localparam logic [ORI_W-1:0] ORI_TILT_BACK       = 5'd9;
    localparam logic [ORI_W-1:0] ORI_TILT_LEFT       = 5'd10;
    localparam logic [ORI_W-1:0] ORI_TILT_RIGHT      = 5'd11;
    localparam logic [ORI_W-1:0] ORI_TILT_LF         = 5'd12;
    localparam logic [ORI_W-1:0] ORI_TILT_LB         = 5'd13;
    localparam logic [ORI_W-1:0] ORI_TILT_RF         = 5'd14;
    localparam logic [ORI_W-1:0] ORI_TILT_RB         = 5'd15;
    localparam logic [ORI_W-1:0] ORI_CORNER_FL       = 5'd16;
    localparam logic [ORI_W-1:0] ORI_CORNER_BL       = 5'd17;
    localparam logic [ORI_W-1:0] ORI_CORNER_FR       = 5'd18;
    localparam logic [ORI_W-1:0] ORI_CORNER_BR       = 5'd19;
    localparam logic [ORI_W-1:0] ORI_FD_TILT_FWD     = 5'd20;
    localparam logic [ORI_W-1:0] ORI_FD_TILT_BACK    = 5'd21;
    localparam logic [ORI_W-1:0] ORI_FD_TILT_RIGHT   = 5'd22;
    localparam logic [ORI_W-1:0] ORI_FD_TILT_LEFT    = 5'd23;
    localparam logic [ORI_W-1:0] ORI_FD_TILT_RF      = 5'd24;
    localparam logic [ORI_W-1:0] ORI_FD_TILT_RB      = 5'd25;
    localparam logic [ORI_W-1:0] ORI_FD_TILT_LF      = 5'd26;
    localparam logic [ORI_W-1:0] ORI_FD_TILT_LB      = 5'd27;
    localparam logic [ORI_W-1:0] ORI_UNCLASSIFIED    = 5'd28;

    // threshold and sign tests on one sample
    typedef struct packed {
        logic z_gt_e;
        logic z_lt_ne;
        logic x_gt_e;
        logic x_lt_ne;
        logic y_gt_e;
        logic y_lt_ne;
        logic z_gt_t;
        logic z_gt_nt;
        logic z_gt_ne;
        logic y_lt_nt;
        logic y_gt_t;
        logic x_gt_t;
        logic x_lt_nt;
        logic x_pos;
        logic y_neg;
    } t_flags;

    // first stage payload
    typedef struct packed {
        logic [SQ_W-1:0] sq_x;
        logic [SQ_W-1:0] sq_y;
        logic [SQ_W-1:0] sq_z;
        t_flags          flags;
    } t_stage1;

    // second stage payload
    typedef struct packed {
        logic [SUM_W-1:0] sum_sq;
        logic [ORI_W-1:0] tree_code;
    } t_stage2;

    // tilt band code, upright or face down
    function automatic logic [ORI_W-1:0] tilt_code(input logic face_down, input t_flags f);
        logic [ORI_W-1:0] code;
        if (f.y_lt_nt) begin
            code = face_down ? ORI_FD_TILT_FWD : ORI_TILT_FWD;
        end else if (f.y_gt_t) begin
            code = face_down ? ORI_FD_TILT_BACK : ORI_TILT_BACK;
        end else if (f.x_gt_t) begin
            code = face_down ? ORI_FD_TILT_RIGHT : ORI_TILT_LEFT;
        end else if (f.x_lt_nt) begin
            code = face_down ? ORI_FD_TILT_LEFT : ORI_TILT_RIGHT;
        end else if (f.x_pos) begin
            if (f.y_neg) begin
                code = face_down ? ORI_FD_TILT_RF : ORI_TILT_LF;
            end else begin
                code = face_down ? ORI_FD_TILT_RB : ORI_TILT_LB;
            end
        end else begin
            if (f.y_neg) begin
                code = face_down ? ORI_FD_TILT_LF : ORI_TILT_RF;
            end else begin
                code = face_down ? ORI_FD_TILT_LB : ORI_TILT_RB;
            end
        end
        return code;
    endfunction

endpackage

@@ design/tilt_orientation_classifier.sv @@
// top level of the tilt orientation classifier: config registers and three stages
//
//  channel   dir  handshake                 payload
//  request   in   start (busy low)          i_accel_x, i_accel_y, i_accel_z
//  result    out  o_done strobe, 1 cycle    o_orientation
//  config    in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one request per cycle, busy stays low; each result strobes o_done once its
// request has passed the square, sum and compare stage registers.
// synchronous active-low reset clears the valid bits and loads the limits.
// a config write stores the squared magnitude limit in the same edge.
// no stall path: the receiver takes every result.
`include "tilt_orientation_classifier_macros.svh"
module tilt_orientation_classifier (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [toc_pkg::ACC_W-1:0]     i_accel_x,
    input  logic signed [toc_pkg::ACC_W-1:0]     i_accel_y,
    input  logic signed [toc_pkg::ACC_W-1:0]     i_accel_z,
    output logic                                 o_done,
    output logic        [toc_pkg::ORI_W-1:0]     o_orientation,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [toc_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic        [toc_pkg::MAG_W-1:0]     i_cfg_data
);

    logic [toc_pkg::MAG_W-1:0]  r_upper;
    logic [toc_pkg::MAG_W-1:0]  r_lower;
    logic [toc_pkg::THR_W-1:0]  r_edge;
    logic [toc_pkg::THR_W-1:0]  r_tilt;
    logic [toc_pkg::SUM_W-1:0]  r_upper_sq;
    logic [toc_pkg::SUM_W-1:0]  r_lower_sq;
    logic [toc_pkg::SUM_W-1:0]  w_cfg_sq;
    logic                       w_cfg_wr;
    logic                       w_accept;
    logic                       w_s1_valid;
    toc_pkg::t_stage1           w_s1_data;
    logic                       w_s2_valid;
    toc_pkg::t_stage2           w_s2_data;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_cfg_sq    = i_cfg_data * i_cfg_data;

    // configuration registers, magnitude limits kept squared too
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper    <= toc_pkg::UPPER_RST;
            r_lower    <= toc_pkg::LOWER_RST;
            r_edge     <= toc_pkg::EDGE_RST;
            r_tilt     <= toc_pkg::TILT_RST;
            r_upper_sq <= toc_pkg::UPPER_SQ_RST;
            r_lower_sq <= toc_pkg::LOWER_SQ_RST;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                toc_pkg::CFG_UPPER: begin
                    r_upper    <= i_cfg_data;
                    r_upper_sq <= w_cfg_sq;
                end
                toc_pkg::CFG_LOWER: begin
                    r_lower    <= i_cfg_data;
                    r_lower_sq <= w_cfg_sq;
                end
                toc_pkg::CFG_EDGE: begin
                    r_edge <= i_cfg_data[toc_pkg::THR_W-1:0];
                end
                toc_pkg::CFG_TILT: begin
                    r_tilt <= i_cfg_data[toc_pkg::THR_W-1:0];
                end
            endcase
        end
    end

    // squares and threshold tests
    toc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_accept),
        .i_accel_x (i_accel_x),
        .i_accel_y (i_accel_y),
        .i_accel_z (i_accel_z),
        .i_edge    (r_edge),
        .i_tilt    (r_tilt),
        .o_valid   (w_s1_valid),
        .o_data    (w_s1_data)
    );

    // sum and decision tree
    toc_tree u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .i_data  (w_s1_data),
        .o_valid (w_s2_valid),
        .o_data  (w_s2_data)
    );

    // magnitude check and result
    toc_resolve u_resolve (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_s2_valid),
        .i_data        (w_s2_data),
        .i_upper_sq    (r_upper_sq),
        .i_lower_sq    (r_lower_sq),
        .o_valid       (o_done),
        .o_orientation (o_orientation)
    );

    // stored squares track the written limits
    `TOC_ASSERT_IMP(a_sq_match, i_clk, i_rst_n, 1'b1, (r_upper_sq == r_upper * r_upper) && (r_lower_sq == r_lower * r_lower), "squared limit out of step")
    // every request gives a result on o_done
    `TOC_ASSERT_NXT(a_req_done, i_clk, i_rst_n, w_accept, ##2 o_done, "request lost in pipeline")
    // no result without a request
    `TOC_ASSERT_IMP(a_done_req, i_clk, i_rst_n, o_done, $past(w_accept, 3), "result without request")
    // result code in range
    `TOC_ASSERT_IMP(a_code_rng, i_clk, i_rst_n, o_done, o_orientation <= toc_pkg::ORI_UNCLASSIFIED, "orientation code out of range")

endmodule

@@ design/toc_front.sv @@
// first stage: axis squares and threshold tests
module toc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [toc_pkg::ACC_W-1:0]    i_accel_x,
    input  logic signed [toc_pkg::ACC_W-1:0]    i_accel_y,
    input  logic signed [toc_pkg::ACC_W-1:0]    i_accel_z,
    input  logic        [toc_pkg::THR_W-1:0]    i_edge,
    input  logic        [toc_pkg::THR_W-1:0]    i_tilt,
    output logic                                o_valid,
    output toc_pkg::t_stage1                    o_data
);

    logic                                r_valid;
    toc_pkg::t_stage1                    r_data;
    toc_pkg::t_stage1                    n_data;
    logic signed [2*toc_pkg::ACC_W-1:0]  w_px;
    logic signed [2*toc_pkg::ACC_W-1:0]  w_py;
    logic signed [2*toc_pkg::ACC_W-1:0]  w_pz;
    logic signed [toc_pkg::ACC_W:0]      w_x;
    logic signed [toc_pkg::ACC_W:0]      w_y;
    logic signed [toc_pkg::ACC_W:0]      w_z;
    logic signed [toc_pkg::ACC_W:0]      w_e;
    logic signed [toc_pkg::ACC_W:0]      w_ne;
    logic signed [toc_pkg::ACC_W:0]      w_t;
    logic signed [toc_pkg::ACC_W:0]      w_nt;

    // one multiplier per axis
    assign w_px = i_accel_x * i_accel_x;
    assign w_py = i_accel_y * i_accel_y;
    assign w_pz = i_accel_z * i_accel_z;

    // common 14-bit signed compare width
    assign w_x  = {i_accel_x[toc_pkg::ACC_W-1], i_accel_x};
    assign w_y  = {i_accel_y[toc_pkg::ACC_W-1], i_accel_y};
    assign w_z  = {i_accel_z[toc_pkg::ACC_W-1], i_accel_z};
    assign w_e  = $signed({2'b00, i_edge});
    assign w_ne = -w_e;
    assign w_t  = $signed({2'b00, i_tilt});
    assign w_nt = -w_t;

    // stage payload
    always_comb begin
        n_data               = '0;
        n_data.sq_x          = w_px[toc_pkg::SQ_W-1:0];
        n_data.sq_y          = w_py[toc_pkg::SQ_W-1:0];
        n_data.sq_z          = w_pz[toc_pkg::SQ_W-1:0];
        n_data.flags.z_gt_e  = w_z > w_e;
        n_data.flags.z_lt_ne = w_z < w_ne;
        n_data.flags.x_gt_e  = w_x > w_e;
        n_data.flags.x_lt_ne = w_x < w_ne;
        n_data.flags.y_gt_e  = w_y > w_e;
        n_data.flags.y_lt_ne = w_y < w_ne;
        n_data.flags.z_gt_t  = w_z > w_t;
        n_data.flags.z_gt_nt = w_z > w_nt;
        n_data.flags.z_gt_ne = w_z > w_ne;
        n_data.flags.y_lt_nt = w_y < w_nt;
        n_data.flags.y_gt_t  = w_y > w_t;
        n_data.flags.x_gt_t  = w_x > w_t;
        n_data.flags.x_lt_nt = w_x < w_nt;
        n_data.flags.x_pos   = w_x > 14'sd0;
        n_data.flags.y_neg   = i_accel_y[toc_pkg::ACC_W-1];
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ design/toc_tree.sv @@
// second stage: sum of squares and orientation decision tree
module toc_tree (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  toc_pkg::t_stage1     i_data,
    output logic                 o_valid,
    output toc_pkg::t_stage2     o_data
);

    logic                        r_valid;
    toc_pkg::t_stage2            r_data;
    toc_pkg::t_stage2            n_data;
    toc_pkg::t_flags             w_f;
    logic [toc_pkg::ORI_W-1:0]   w_code;

    assign w_f = i_data.flags;

    // fixed decision tree, faces and edges first
    always_comb begin
        if (w_f.z_gt_e) begin
            w_code = toc_pkg::ORI_FACE_UP;
        end else if (w_f.z_lt_ne) begin
            w_code = toc_pkg::ORI_FACE_DOWN;
        end else if (w_f.x_gt_e) begin
            w_code = toc_pkg::ORI_LEFT_EDGE;
        end else if (w_f.x_lt_ne) begin
            w_code = toc_pkg::ORI_RIGHT_EDGE;
        end else if (w_f.y_gt_e) begin
            w_code = toc_pkg::ORI_BACK_EDGE;
        end else if (w_f.y_lt_ne) begin
            w_code = toc_pkg::ORI_FRONT_EDGE;
        end else if (w_f.z_gt_t) begin
            w_code = toc_pkg::tilt_code(1'b0, w_f);
        end else if (w_f.z_gt_nt) begin
            if (w_f.x_pos) begin
                w_code = w_f.y_neg ? toc_pkg::ORI_CORNER_FL : toc_pkg::ORI_CORNER_BL;
            end else begin
                w_code = w_f.y_neg ? toc_pkg::ORI_CORNER_FR : toc_pkg::ORI_CORNER_BR;
            end
        end else if (w_f.z_gt_ne) begin
            w_code = toc_pkg::tilt_code(1'b1, w_f);
        end else begin
            w_code = toc_pkg::ORI_UNCLASSIFIED;
        end
    end

    // stage payload
    always_comb begin
        n_data.sum_sq    = {1'b0, i_data.sq_x} + {1'b0, i_data.sq_y} + {1'b0, i_data.sq_z};
        n_data.tree_code = w_code;
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ design/toc_resolve.sv @@
// third stage: magnitude check against squared limits, result register
module toc_resolve (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  toc_pkg::t_stage2           i_data,
    input  logic [toc_pkg::SUM_W-1:0]  i_upper_sq,
    input  logic [toc_pkg::SUM_W-1:0]  i_lower_sq,
    output logic                       o_valid,
    output logic [toc_pkg::ORI_W-1:0]  o_orientation
);

    logic                        r_valid;
    logic [toc_pkg::ORI_W-1:0]   r_code;
    logic [toc_pkg::ORI_W-1:0]   n_code;

    // accelerating wins over falling
    always_comb begin
        if (i_data.sum_sq > i_upper_sq) begin
            n_code = toc_pkg::ORI_ACCEL;
        end else if (i_data.sum_sq < i_lower_sq) begin
            n_code = toc_pkg::ORI_FALL;
        end else begin
            n_code = i_data.tree_code;
        end
    end

    // strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_valid       = r_valid;
    assign o_orientation = r_code;

endmodule
